// ===== rtl/gcfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gcfs_pkg;

    // Default sizes
    localparam int EDGE_ID_BITS_DEF = 16;
    localparam int MAX_NEARBY_DEF   = 64;

    // Fixed field widths
    localparam int ID_W     = 16;
    localparam int UTIL_W   = 32;
    localparam int COST_W   = 32;
    localparam int TOTAL_W  = 48;

    // Item function codes
    localparam logic [1:0] FUNC_NEW   = 2'd0;
    localparam logic [1:0] FUNC_BEGIN = 2'd1;
    localparam logic [1:0] FUNC_EDGE  = 2'd2;
    localparam logic [1:0] FUNC_END   = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_start;   // new run: reset totals, restart bitmap sweep
        logic clr_step;    // clear one bitmap entry
        logic begin_load;  // latch candidate header
        logic edge_load;   // bitmap lookup and buffer one element
        logic edge_check;  // fold bitmap read data into conflict flag
        logic end_eval;    // decide, update totals, load result
        logic wb_step;     // read one buffered element for write-back
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;    // sweep at last entry
        logic take_wb;     // candidate taken with elements to write back
        logic wb_last;     // write-back read at last element
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/gcfs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gcfs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_func,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output gcfs_pkg::t_cmd         o_cmd,
    input  wire gcfs_pkg::t_status i_status
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EDGE  = 3'd2;
    localparam logic [2:0] ST_WB    = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;

    // Input handshake: only idle takes items; an end waits for a free result slot
    always_comb begin
        o_in_stall = (r_state != ST_IDLE) ||
                     (r_out_valid && (i_func == gcfs_pkg::FUNC_END));
        w_accept   = i_in_valid && !o_in_stall;
    end

    // Command decode
    always_comb begin
        o_cmd            = '0;
        o_cmd.clr_start  = w_accept && (i_func == gcfs_pkg::FUNC_NEW);
        o_cmd.begin_load = w_accept && (i_func == gcfs_pkg::FUNC_BEGIN);
        o_cmd.edge_load  = w_accept && (i_func == gcfs_pkg::FUNC_EDGE);
        o_cmd.end_eval   = w_accept && (i_func == gcfs_pkg::FUNC_END);
        o_cmd.clr_step   = (r_state == ST_CLEAR);
        o_cmd.edge_check = (r_state == ST_EDGE);
        o_cmd.wb_step    = (r_state == ST_WB);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_cmd.clr_start) begin
                    n_state = ST_CLEAR;
                end else if (o_cmd.edge_load) begin
                    n_state = ST_EDGE;
                end else if (o_cmd.end_eval && i_status.take_wb) begin
                    n_state = ST_WB;
                end
            end
            ST_EDGE: begin
                n_state = ST_IDLE;
            end
            ST_WB: begin
                if (i_status.wb_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result slot occupancy
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.end_eval) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    // An end decision always produces a result next cycle
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.end_eval |=> r_out_valid)
        else $error("end transfer did not load a result");

    // Sweep continues until the last entry
    a_clear_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && !i_status.clr_last) |=> (r_state == ST_CLEAR))
        else $error("bitmap sweep ended early");

    // Edge check state always returns straight to idle
    a_edge_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EDGE) |=> (r_state == ST_IDLE))
        else $error("edge check state held");

    // Write-back leaves only through the drain state
    a_wb_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB) |=> (r_state == ST_WB || r_state == ST_DRAIN))
        else $error("write-back left without drain");
`endif

endmodule

`default_nettype wire

// ===== rtl/gcfs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gcfs_datapath #(
    parameter int EDGE_ID_BITS = gcfs_pkg::EDGE_ID_BITS_DEF,
    parameter int MAX_NEARBY   = gcfs_pkg::MAX_NEARBY_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire gcfs_pkg::t_cmd                     i_cmd,
    output gcfs_pkg::t_status                       o_status,
    input  wire logic                               i_cfg_we,
    input  wire logic [gcfs_pkg::TOTAL_W-1:0]       i_cfg_data,
    input  wire logic [gcfs_pkg::ID_W-1:0]          i_edge_id,
    input  wire logic signed [gcfs_pkg::UTIL_W-1:0] i_edge_utility,
    input  wire logic [gcfs_pkg::COST_W-1:0]        i_edge_cost,
    input  wire logic                               i_key_known,
    output logic                                    o_accepted,
    output logic signed [gcfs_pkg::TOTAL_W-1:0]     o_objective_total,
    output logic [gcfs_pkg::TOTAL_W-1:0]            o_cost_total,
    output logic                                    o_set_overflow
);

    localparam int TW       = gcfs_pkg::TOTAL_W;
    localparam int UW       = gcfs_pkg::UTIL_W;
    localparam int CW       = gcfs_pkg::COST_W;
    localparam int MAP_DEPTH = 1 << EDGE_ID_BITS;
    localparam int CNT_W    = $clog2(MAX_NEARBY + 1);
    localparam int IDX_W    = (MAX_NEARBY > 1) ? $clog2(MAX_NEARBY) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NEARBY);

    // Forbidden-edge bitmap and element buffer
    logic                    r_map [MAP_DEPTH];
    logic                    r_map_rd;
    logic [EDGE_ID_BITS-1:0] r_set [MAX_NEARBY];
    logic [EDGE_ID_BITS-1:0] r_set_rd;

    // Control registers
    logic [EDGE_ID_BITS-1:0] r_clr_addr;
    logic [CNT_W-1:0]        r_pend_count;
    logic                    r_conflict;
    logic                    r_overflow;
    logic                    r_pend_known;
    logic [CNT_W-1:0]        r_wb_idx;
    logic [CNT_W-1:0]        r_wb_num;
    logic                    r_wr_pend;
    logic [TW-1:0]           r_budget;
    logic [TW-1:0]           r_obj_sum;
    logic [TW-1:0]           r_cost_sum;

    // Payload registers
    logic [UW-1:0]           r_pend_util;
    logic [CW-1:0]           r_pend_cost;
    logic                    r_o_accepted;
    logic [TW-1:0]           r_o_obj;
    logic [TW-1:0]           r_o_cost;
    logic                    r_o_overflow;

    logic [EDGE_ID_BITS+gcfs_pkg::ID_W-1:0] w_id_wide;
    logic [EDGE_ID_BITS-1:0] w_id;
    logic                    w_buf_room;
    logic [TW:0]             w_cost_add;
    logic [TW:0]             w_obj_add;
    logic                    w_fits;
    logic                    w_take;
    logic [TW-1:0]           w_new_obj;
    logic [TW-1:0]           w_new_cost;
    logic                    w_map_we;
    logic [EDGE_ID_BITS-1:0] w_map_wa;
    logic                    w_map_wd;

    // Edge id masked to the bitmap size
    assign w_id_wide  = {{EDGE_ID_BITS{1'b0}}, i_edge_id};
    assign w_id       = w_id_wide[EDGE_ID_BITS-1:0];
    assign w_buf_room = (r_pend_count < CNT_MAX);

    // Budget check and saturating totals
    always_comb begin
        w_cost_add = {1'b0, r_cost_sum} + {{(TW + 1 - CW){1'b0}}, r_pend_cost};
        w_obj_add  = {r_obj_sum[TW-1], r_obj_sum}
                   + {{(TW + 1 - UW){r_pend_util[UW-1]}}, r_pend_util};
        w_fits     = (&r_budget) || (w_cost_add <= {1'b0, r_budget});
        w_take     = r_pend_known && w_fits && !r_conflict && !r_overflow;
        if (w_obj_add[TW] != w_obj_add[TW-1]) begin
            w_new_obj = w_obj_add[TW] ? {1'b1, {(TW - 1){1'b0}}}
                                      : {1'b0, {(TW - 1){1'b1}}};
        end else begin
            w_new_obj = w_obj_add[TW-1:0];
        end
        w_new_cost = w_cost_add[TW] ? {TW{1'b1}} : w_cost_add[TW-1:0];
    end

    // Status to controller
    always_comb begin
        o_status          = '0;
        o_status.clr_last = &r_clr_addr;
        o_status.take_wb  = w_take && (r_pend_count != '0);
        o_status.wb_last  = ((r_wb_idx + CNT_W'(1)) == r_wb_num);
    end

    // Bitmap write port: sweep clears, write-back marks
    always_comb begin
        w_map_we = i_cmd.clr_step || r_wr_pend;
        w_map_wa = i_cmd.clr_step ? r_clr_addr : r_set_rd;
        w_map_wd = !i_cmd.clr_step;
    end

    // Bitmap memory
    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map[w_map_wa] <= w_map_wd;
        end
        r_map_rd <= r_map[w_id];
    end

    // Element buffer memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_load && w_buf_room) begin
            r_set[r_pend_count[IDX_W-1:0]] <= w_id;
        end
        r_set_rd <= r_set[r_wb_idx[IDX_W-1:0]];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_pend_count <= '0;
            r_conflict   <= 1'b0;
            r_overflow   <= 1'b0;
            r_pend_known <= 1'b0;
            r_wb_idx     <= '0;
            r_wb_num     <= '0;
            r_wr_pend    <= 1'b0;
            r_budget     <= {TW{1'b1}};
            r_obj_sum    <= '0;
            r_cost_sum   <= '0;
        end else begin
            r_wr_pend <= i_cmd.wb_step;
            if (i_cfg_we) begin
                r_budget <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + EDGE_ID_BITS'(1);
            end
            if (i_cmd.wb_step) begin
                r_wb_idx <= r_wb_idx + CNT_W'(1);
            end
            if (i_cmd.edge_check && r_map_rd) begin
                r_conflict <= 1'b1;
            end
            if (i_cmd.edge_load) begin
                if (w_buf_room) begin
                    r_pend_count <= r_pend_count + CNT_W'(1);
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            if (i_cmd.clr_start || i_cmd.begin_load || i_cmd.end_eval) begin
                r_pend_count <= '0;
                r_conflict   <= 1'b0;
                r_overflow   <= 1'b0;
                r_pend_known <= i_cmd.begin_load && i_key_known;
            end
            if (i_cmd.clr_start) begin
                r_clr_addr <= '0;
                r_obj_sum  <= '0;
                r_cost_sum <= '0;
            end
            if (i_cmd.end_eval) begin
                r_wb_idx <= '0;
                r_wb_num <= r_pend_count;
                if (w_take) begin
                    r_obj_sum  <= w_new_obj;
                    r_cost_sum <= w_new_cost;
                end
            end
        end
    end

    // Candidate header and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_start || i_cmd.end_eval) begin
            r_pend_util <= '0;
            r_pend_cost <= '0;
        end else if (i_cmd.begin_load) begin
            r_pend_util <= i_edge_utility;
            r_pend_cost <= i_edge_cost;
        end
        if (i_cmd.end_eval) begin
            r_o_accepted <= w_take;
            r_o_obj      <= w_take ? w_new_obj : r_obj_sum;
            r_o_cost     <= w_take ? w_new_cost : r_cost_sum;
            r_o_overflow <= r_overflow;
        end
    end

    assign o_accepted        = r_o_accepted;
    assign o_objective_total = r_o_obj;
    assign o_cost_total      = r_o_cost;
    assign o_set_overflow    = r_o_overflow;

endmodule

`default_nettype wire

// ===== rtl/greedy_conflict_free_selector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// An end item's result is registered and valid in the cycle after its transfer.
// Begin items are taken without holding the input; edge items hold it for a bitmap
//   read, end items with accepted elements for their bitmap write-back and a drain state.
// Reset (synchronous, active low) and each new-run item start a bitmap clear
//   sweep over all 2^EDGE_ID_BITS entries, one entry per cycle, with input stalled.
// Reset sets the budget to all ones (unlimited) and zeroes totals and pending state.
module greedy_conflict_free_selector_unit #(
    parameter int EDGE_ID_BITS = gcfs_pkg::EDGE_ID_BITS_DEF,
    parameter int MAX_NEARBY   = gcfs_pkg::MAX_NEARBY_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [gcfs_pkg::TOTAL_W-1:0]       i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [1:0]                         i_func,
    input  wire logic [gcfs_pkg::ID_W-1:0]          i_edge_id,
    input  wire logic signed [gcfs_pkg::UTIL_W-1:0] i_edge_utility,
    input  wire logic [gcfs_pkg::COST_W-1:0]        i_edge_cost,
    input  wire logic                               i_key_known,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_accepted,
    output logic signed [gcfs_pkg::TOTAL_W-1:0]     o_objective_total,
    output logic [gcfs_pkg::TOTAL_W-1:0]            o_cost_total,
    output logic                                    o_set_overflow
);

    gcfs_pkg::t_cmd    w_cmd;
    gcfs_pkg::t_status w_status;

    // Sequencer
    gcfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Bitmap, element buffer and totals
    gcfs_datapath #(
        .EDGE_ID_BITS (EDGE_ID_BITS),
        .MAX_NEARBY   (MAX_NEARBY)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_edge_id         (i_edge_id),
        .i_edge_utility    (i_edge_utility),
        .i_edge_cost       (i_edge_cost),
        .i_key_known       (i_key_known),
        .o_accepted        (o_accepted),
        .o_objective_total (o_objective_total),
        .o_cost_total      (o_cost_total),
        .o_set_overflow    (o_set_overflow)
    );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import gcfs_pkg::*;

    localparam int MAP_DEPTH   = 1 << EDGE_ID_BITS_DEF;
    localparam int HOLD_CAP    = MAX_NEARBY_DEF;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 200;
    localparam int SETTLE      = MAX_NEARBY_DEF + 8;
    localparam int IDLE_LIMIT  = 200000;
    localparam int HOLD_OFF    = 400;
    localparam int HOLD_AFTER  = 100;

    localparam logic [ID_W-1:0]           ID_MASK  = ID_W'(MAP_DEPTH - 1);
    localparam logic [TOTAL_W-1:0]        NO_LIMIT = {TOTAL_W{1'b1}};
    localparam logic signed [TOTAL_W-1:0] OBJ_MAX  = {1'b0, {(TOTAL_W - 1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] OBJ_MIN  = {1'b1, {(TOTAL_W - 1){1'b0}}};

    typedef struct packed {
        logic [1:0]               func;
        logic [ID_W-1:0]          id;
        logic signed [UTIL_W-1:0] util;
        logic [COST_W-1:0]        cost;
        logic                     known;
    } sel_item_t;

    typedef struct packed {
        logic                      accepted;
        logic signed [TOTAL_W-1:0] objective;
        logic [TOTAL_W-1:0]        cost;
        logic                      overflow;
    } sel_result_t;

    // One directed step; edge rows repeat with consecutive ids
    typedef struct packed {
        sel_item_t   item;
        int          reps;
        bit          typed;
        sel_result_t want;
    } plan_row_t;

    // DUT ports
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [TOTAL_W-1:0]        i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [1:0]                i_func = FUNC_NEW;
    logic [ID_W-1:0]           i_edge_id = '0;
    logic signed [UTIL_W-1:0]  i_edge_utility = '0;
    logic [COST_W-1:0]         i_edge_cost = '0;
    logic                      i_key_known = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic                      o_accepted;
    logic signed [TOTAL_W-1:0] o_objective_total;
    logic [TOTAL_W-1:0]        o_cost_total;
    logic                      o_set_overflow;

    // Shadow state of the selector
    bit                        blocked_edges [MAP_DEPTH];
    logic [ID_W-1:0]           held_ids [HOLD_CAP];
    int                        held_count = 0;
    bit                        hit_blocked = 1'b0;
    bit                        too_many = 1'b0;
    logic signed [UTIL_W-1:0]  cand_utility = '0;
    logic [COST_W-1:0]         cand_cost = '0;
    bit                        cand_known = 1'b0;
    logic signed [TOTAL_W-1:0] run_objective = '0;
    logic [TOTAL_W-1:0]        run_cost = '0;
    logic [TOTAL_W-1:0]        budget_now = NO_LIMIT;

    sel_result_t expected_totals [$];
    plan_row_t   plan [$];

    int mismatches   = 0;
    int results_seen = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;
    int gap_pct      = 15;
    int stall_pct    = 5;
    bit held_off     = 1'b0;

    greedy_conflict_free_selector_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_edge_id         (i_edge_id),
        .i_edge_utility    (i_edge_utility),
        .i_edge_cost       (i_edge_cost),
        .i_key_known       (i_key_known),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_accepted        (o_accepted),
        .o_objective_total (o_objective_total),
        .o_cost_total      (o_cost_total),
        .o_set_overflow    (o_set_overflow)
    );

    always #1 i_clk = ~i_clk;

    function automatic void clear_candidate();
        held_count   = 0;
        hit_blocked  = 1'b0;
        too_many     = 1'b0;
        cand_utility = '0;
        cand_cost    = '0;
        cand_known   = 1'b0;
    endfunction

    // Advance the shadow state by one item; returns 1 when the item yields totals
    function automatic bit predict_selection(input sel_item_t it, output sel_result_t res);
        logic [TOTAL_W:0]        cost_next;
        logic signed [TOTAL_W:0] obj_next;
        logic [ID_W-1:0]         id;
        bit                      fits;
        bit                      take;
        res = '0;
        case (it.func)
            FUNC_NEW: begin
                foreach (blocked_edges[k]) blocked_edges[k] = 1'b0;
                clear_candidate();
                run_objective = '0;
                run_cost      = '0;
                return 1'b0;
            end
            FUNC_BEGIN: begin
                clear_candidate();
                cand_utility = it.util;
                cand_cost    = it.cost;
                cand_known   = it.known;
                return 1'b0;
            end
            FUNC_EDGE: begin
                id = it.id & ID_MASK;
                if (blocked_edges[id]) hit_blocked = 1'b1;
                if (held_count < HOLD_CAP) begin
                    held_ids[held_count] = id;
                    held_count++;
                end else begin
                    too_many = 1'b1;
                end
                return 1'b0;
            end
            default: begin
                // budget check is exact: 49-bit sum, no wrap
                cost_next = run_cost + cand_cost;
                fits = (budget_now == NO_LIMIT) || (cost_next <= {1'b0, budget_now});
                take = cand_known && fits && !hit_blocked && !too_many;
                if (take) begin
                    obj_next = run_objective + cand_utility;
                    for (int k = 0; k < held_count; k++) blocked_edges[held_ids[k]] = 1'b1;
                    if (obj_next > OBJ_MAX) run_objective = OBJ_MAX;
                    else if (obj_next < OBJ_MIN) run_objective = OBJ_MIN;
                    else run_objective = obj_next[TOTAL_W-1:0];
                    run_cost = cost_next[TOTAL_W] ? NO_LIMIT : cost_next[TOTAL_W-1:0];
                end
                res.accepted  = take;
                res.objective = run_objective;
                res.cost      = run_cost;
                res.overflow  = too_many;
                clear_candidate();
                return 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    function automatic sel_item_t random_fields();
        sel_item_t it;
        it.func  = 2'($urandom);
        it.id    = ID_W'($urandom);
        it.util  = UTIL_W'($urandom);
        it.cost  = COST_W'($urandom);
        it.known = 1'($urandom);
        return it;
    endfunction

    function automatic void step_row(input logic [1:0] f, input logic [ID_W-1:0] id,
                                     input logic [UTIL_W-1:0] util,
                                     input logic [COST_W-1:0] cost,
                                     input logic known, input int reps);
        plan_row_t r;
        r.item  = '{func: f, id: id, util: util, cost: cost, known: known};
        r.reps  = reps;
        r.typed = 1'b0;
        r.want  = '0;
        plan = {plan, r};
    endfunction

    // End row whose totals are known by inspection
    function automatic void check_row(input logic acc, input logic [TOTAL_W-1:0] obj,
                                      input logic [TOTAL_W-1:0] cst, input logic ovf);
        plan_row_t r;
        r.item  = '0;
        r.item.func = FUNC_END;
        r.reps  = 1;
        r.typed = 1'b1;
        r.want  = '{accepted: acc, objective: obj, cost: cst, overflow: ovf};
        plan = {plan, r};
    endfunction

    // Offer one item, hold it until the transfer, then record the expectation
    task automatic send_item(input sel_item_t it, input bit typed, input sel_result_t want);
        sel_result_t res;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= it.func;
        i_edge_id      <= it.id;
        i_edge_utility <= it.util;
        i_edge_cost    <= it.cost;
        i_key_known    <= it.known;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if (predict_selection(it, res)) expected_totals = {expected_totals, typed ? want : res};
    endtask

    // Drop valid, wait for all totals, then let write-back finish
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_totals.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_budget(input logic [TOTAL_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        budget_now = value;
    endtask

    // One candidate: mostly well formed, some stray or unterminated
    task automatic run_candidate();
        sel_item_t       it;
        int              n;
        int              roll;
        logic [ID_W-1:0] last_id;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            it = random_fields();
            it.func = 2'($urandom_range(FUNC_BEGIN, FUNC_END));
            send_item(it, 1'b0, '0);
            return;
        end
        it = random_fields();
        it.func = FUNC_BEGIN;
        if ($urandom_range(0, 1) == 0)
            it.util = UTIL_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        roll = $urandom_range(0, 9);
        if (roll < 5) it.cost = COST_W'($urandom_range(0, 1 << 20));
        else if (roll < 7) it.cost = '0;
        it.known = ($urandom_range(0, 9) != 0);
        send_item(it, 1'b0, '0);

        roll = $urandom_range(0, 99);
        if (roll < 85) n = $urandom_range(0, 8);
        else if (roll < 95) n = $urandom_range(9, 63);
        else n = $urandom_range(HOLD_CAP - 4, HOLD_CAP + 6);
        last_id = '0;
        for (int k = 0; k < n; k++) begin
            it = random_fields();
            it.func = FUNC_EDGE;
            roll = $urandom_range(0, 99);
            if (roll < 45) it.id = ID_W'($urandom_range(0, 511));
            else if (roll < 55) it.id = last_id;
            send_item(it, 1'b0, '0);
            last_id = it.id;
        end
        // now and then the end is left out; the next begin discards the candidate
        if ($urandom_range(0, 19) != 0) begin
            it = random_fields();
            it.func = FUNC_END;
            send_item(it, 1'b0, '0);
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        sel_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_totals.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_accepted), 64'd0);
            end else begin
                want = expected_totals.pop_front();
                if (o_accepted !== want.accepted)
                    report_mismatch("accepted", 64'(o_accepted), 64'(want.accepted));
                if (o_objective_total !== want.objective)
                    report_mismatch("objective_total", 64'(o_objective_total),
                                    64'(want.objective));
                if (o_cost_total !== want.cost)
                    report_mismatch("cost_total", 64'(o_cost_total), 64'(want.cost));
                if (o_set_overflow !== want.overflow)
                    report_mismatch("set_overflow", 64'(o_set_overflow), 64'(want.overflow));
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off to back the block up
    initial begin
        forever begin
            @(posedge i_clk);
            if (!held_off && results_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Main sequence
    initial begin
        sel_item_t          it;
        logic [TOTAL_W-1:0] limit;

        // End with no begin, then a max-utility max-cost candidate
        check_row(1'b0, 48'h0, 48'h0, 1'b0);
        step_row(FUNC_BEGIN, 16'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1);
        step_row(FUNC_EDGE, 16'hFFFF, 32'h0, 32'h0, 1'b0, 1);
        step_row(FUNC_EDGE, 16'h0000, 32'h0, 32'h0, 1'b0, 1);
        check_row(1'b1, 48'h0000_7FFF_FFFF, 48'h0000_FFFF_FFFF, 1'b0);
        // Touches a blocked edge, then a repeated end
        step_row(FUNC_BEGIN, 16'h0, 32'h8000_0000, 32'h0, 1'b1, 1);
        step_row(FUNC_EDGE, 16'h0000, 32'h0, 32'h0, 1'b0, 1);
        check_row(1'b0, 48'h0000_7FFF_FFFF, 48'h0000_FFFF_FFFF, 1'b0);
        check_row(1'b0, 48'h0000_7FFF_FFFF, 48'h0000_FFFF_FFFF, 1'b0);
        // Duplicate ids inside one candidate, most negative utility
        step_row(FUNC_BEGIN, 16'h0, 32'h8000_0000, 32'h0, 1'b1, 1);
        step_row(FUNC_EDGE, 16'h0001, 32'h0, 32'h0, 1'b0, 1);
        step_row(FUNC_EDGE, 16'h0001, 32'h0, 32'h0, 1'b0, 1);
        check_row(1'b1, 48'hFFFF_FFFF_FFFF, 48'h0000_FFFF_FFFF, 1'b0);
        // Unknown key is always skipped
        step_row(FUNC_BEGIN, 16'h0, 32'h1, 32'h1, 1'b0, 1);
        step_row(FUNC_EDGE, 16'h0002, 32'h0, 32'h0, 1'b0, 1);
        check_row(1'b0, 48'hFFFF_FFFF_FFFF, 48'h0000_FFFF_FFFF, 1'b0);
        // Stray edge, full buffer, one past full
        step_row(FUNC_EDGE, 16'h0003, 32'h0, 32'h0, 1'b0, 1);
        step_row(FUNC_BEGIN, 16'h0, 32'h0001_0000, 32'h0001_0000, 1'b1, 1);
        step_row(FUNC_EDGE, 16'h0100, 32'h0, 32'h0, 1'b0, HOLD_CAP);
        step_row(FUNC_END, 16'h0, 32'h0, 32'h0, 1'b0, 1);
        step_row(FUNC_BEGIN, 16'h0, 32'h0001_0000, 32'h0001_0000, 1'b1, 1);
        step_row(FUNC_EDGE, 16'h0200, 32'h0, 32'h0, 1'b0, HOLD_CAP + 1);
        step_row(FUNC_END, 16'h0, 32'h0, 32'h0, 1'b0, 1);
        // New run frees every edge and zeroes the totals
        step_row(FUNC_NEW, 16'h0, 32'h0, 32'h0, 1'b0, 1);
        step_row(FUNC_BEGIN, 16'h0, 32'h0, 32'h0, 1'b1, 1);
        step_row(FUNC_EDGE, 16'h0000, 32'h0, 32'h0, 1'b0, 1);
        check_row(1'b1, 48'h0, 48'h0, 1'b0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            for (int k = 0; k < plan[r].reps; k++) begin
                it = plan[r].item;
                it.id = plan[r].item.id + ID_W'(k);
                send_item(it, plan[r].typed, plan[r].want);
            end
        end

        // Random phases, each with its own budget
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0, 5:    limit = NO_LIMIT;
                1:       limit = '0;
                2:       limit = {16'($urandom_range(1, 6)), 32'($urandom)};
                3:       limit = NO_LIMIT - 1;
                default: limit = {16'($urandom), 32'($urandom)};
            endcase
            write_budget(limit);
            if (phase == PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if (phase == 1) begin
                gap_pct   = 3;
                stall_pct = 1;
            end else begin
                gap_pct   = 15;
                stall_pct = 5;
            end
            if (phase != 3 && phase != 5) begin
                it = random_fields();
                it.func = FUNC_NEW;
                send_item(it, 1'b0, '0);
            end
            limit = TOTAL_W'(items_sent + PHASE_ITEMS);
            while (items_sent < limit) run_candidate();
        end

        drain();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
